### rtl/pru_pkg.sv
package pru_pkg;

  localparam int unsigned RAW_W             = 8;
  localparam int unsigned BPP_W             = 3;
  localparam int unsigned ROW_BYTES_W       = 13;
  localparam int unsigned CFG_DATA_W        = 13;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned MAX_BPP           = 4;
  localparam int unsigned MAX_ROW_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH       = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd7
  } filter_e;

  // data byte as handed from front to back, column travels beside it
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    filter_e          kind;
    logic             first_row;
    logic             has_left;
    logic             row_end;
    logic             bad_filter;
  } item_t;

  // paeth predictor: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  function automatic logic [RAW_W-1:0] paeth(input logic [RAW_W-1:0] a,
                                             input logic [RAW_W-1:0] b,
                                             input logic [RAW_W-1:0] c);
    logic [RAW_W:0]   pa;
    logic [RAW_W:0]   pb;
    logic [RAW_W+1:0] s;
    logic [RAW_W+1:0] two_c;
    logic [RAW_W+1:0] pc;
    pa    = (b >= c) ? ((RAW_W+1)'(b) - (RAW_W+1)'(c)) : ((RAW_W+1)'(c) - (RAW_W+1)'(b));
    pb    = (a >= c) ? ((RAW_W+1)'(a) - (RAW_W+1)'(c)) : ((RAW_W+1)'(c) - (RAW_W+1)'(a));
    s     = (RAW_W+2)'(a) + (RAW_W+2)'(b);
    two_c = {1'b0, c, 1'b0};
    pc    = (s >= two_c) ? (s - two_c) : (two_c - s);
    if (pa <= pb && {1'b0, pa} <= pc) begin
      return a;
    end else if ({1'b0, pb} <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

### rtl/pru_in_if.sv
interface pru_in_if
  import pru_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] stream_byte;
  logic             image_start;

  modport source (output valid, output stream_byte, output image_start, input ready);
  modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

### rtl/pru_out_if.sv
interface pru_out_if
  import pru_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] pixel_byte;
  logic             row_end;
  logic             bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                  output ready);
endinterface

### rtl/pru_ram.sv
module pru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a shared address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pru_front.sv
module pru_front
  import pru_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pru_in_if.sink                             in_ch,
  input  logic [BPP_W-1:0]                   bpp_i,
  input  logic [$clog2(MAX_ROW_BYTES+1)-1:0] row_bytes_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output item_t                              q_item_o,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]   q_col_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int unsigned COL_W  = $clog2(MAX_ROW_BYTES + 1);

  logic              await_q, await_d;
  logic              first_q, first_d;
  logic              err_q, err_d;
  filter_e           kind_q, kind_d;
  logic [ADDR_W-1:0] col_q, col_d;

  logic              acc;
  logic              eff_await;
  logic              eff_first;
  logic              eff_err;
  logic [COL_W-1:0]  col_next;
  logic              row_end;

  assign in_ch.ready = !q_full_i;
  assign acc         = in_ch.valid && !q_full_i;

  assign eff_await = await_q || in_ch.image_start;
  assign eff_first = first_q || in_ch.image_start;
  assign eff_err   = err_q && !in_ch.image_start;
  assign col_next  = COL_W'(col_q) + COL_W'(1);
  assign row_end   = (col_next >= row_bytes_i);

  always_comb begin
    await_d = await_q;
    first_d = first_q;
    err_d   = err_q;
    kind_d  = kind_q;
    col_d   = col_q;
    if (acc) begin
      if (eff_await) begin
        await_d = 1'b0;
        first_d = eff_first;
        col_d   = '0;
        if (in_ch.stream_byte > RAW_W'(FILT_PAETH)) begin
          err_d  = 1'b1;
          kind_d = FILT_BAD;
        end else begin
          err_d  = eff_err;
          kind_d = filter_e'(in_ch.stream_byte[2:0]);
        end
      end else if (row_end) begin
        await_d = 1'b1;
        first_d = 1'b0;
        col_d   = '0;
      end else begin
        col_d = col_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b1;
      first_q <= 1'b1;
      err_q   <= 1'b0;
      kind_q  <= FILT_NONE;
      col_q   <= '0;
    end else begin
      await_q <= await_d;
      first_q <= first_d;
      err_q   <= err_d;
      kind_q  <= kind_d;
      col_q   <= col_d;
    end
  end

  // filter type bytes stop here, data bytes go on to the back end
  assign q_push_o            = acc && !eff_await;
  assign q_col_o             = col_q;
  assign q_item_o.raw        = in_ch.stream_byte;
  assign q_item_o.kind       = kind_q;
  assign q_item_o.first_row  = first_q;
  assign q_item_o.has_left   = (COL_W'(col_q) >= COL_W'(bpp_i));
  assign q_item_o.row_end    = row_end;
  assign q_item_o.bad_filter = err_q;

endmodule

### rtl/pru_queue.sv
module pru_queue #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/pru_back.sv
module pru_back
  import pru_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [BPP_W-1:0]                 bpp_i,
  input  logic                             q_empty_i,
  input  item_t                            q_item_i,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0] q_col_i,
  output logic                             q_pop_o,
  pru_out_if.source                        out_ch
);

  localparam int unsigned ADDR_W = $clog2(MAX_ROW_BYTES);

  logic                  s1_valid_q;
  item_t                 s1_item_q;
  logic [ADDR_W-1:0]     s1_col_q;
  logic                  byp_q;
  logic [RAW_W-1:0]      byp_val_q;
  logic [3:0][RAW_W-1:0] left_q;
  logic [3:0][RAW_W-1:0] upleft_q;
  logic                  out_valid_q;
  logic [RAW_W-1:0]      out_pix_q;
  logic                  out_end_q;
  logic                  out_bad_q;

  logic                  fire;
  logic                  pop;
  logic [RAW_W-1:0]      ram_rdata;
  logic [1:0]            tap;
  logic [RAW_W-1:0]      a, b, c, pred, val;
  logic [RAW_W:0]        avg_sum;

  assign fire    = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign pop     = !q_empty_i && (!s1_valid_q || fire);
  assign q_pop_o = pop;

  pru_ram #(
    .WIDTH (RAW_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s1_col_q),
    .wdata_i (val),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (ram_rdata)
  );

  // neighbour selection, tap sits bpp bytes back
  assign tap = 2'(bpp_i - BPP_W'(1));
  assign a   = s1_item_q.has_left ? left_q[tap] : '0;
  assign b   = s1_item_q.first_row ? '0 : (byp_q ? byp_val_q : ram_rdata);
  assign c   = (s1_item_q.has_left && !s1_item_q.first_row) ? upleft_q[tap] : '0;

  assign avg_sum = (RAW_W+1)'(a) + (RAW_W+1)'(b);

  always_comb begin
    case (s1_item_q.kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[RAW_W:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = '0;
    endcase
  end

  assign val = s1_item_q.raw + pred;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q <= q_item_i;
      s1_col_q  <= q_col_i;
      byp_val_q <= val;
    end
    if (fire) begin
      out_pix_q <= val;
      out_end_q <= s1_item_q.row_end;
      out_bad_q <= s1_item_q.bad_filter;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      upleft_q    <= '0;
    end else begin
      if (pop) begin
        s1_valid_q <= 1'b1;
        // the byte being written now is not yet in the ram read result
        byp_q      <= fire && (s1_col_q == q_col_i);
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        left_q      <= {left_q[2:0], val};
        upleft_q    <= {upleft_q[2:0], b};
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.pixel_byte = out_pix_q;
  assign out_ch.row_end    = out_end_q;
  assign out_ch.bad_filter = out_bad_q;

endmodule

### rtl/png_row_unfilter.sv
// png scanline unfilter: takes the inflated scanline stream one byte per transaction and
// returns one reconstructed byte per data byte; the filter type byte that opens each row
// is consumed without a result. sustained rate is one input byte per cycle unless the
// output stalls, set by the single line store ram (one write and one read port) and the
// one-byte compute stage; data bytes pass the queue, compute stage register and output
// register. the front end tracks column, row and filter type and feeds a short queue, the
// back end reads the upper byte from the line store, applies the predictor and writes the
// result back. the line store is not cleared: every image's first row reads zero above.
// set bytes_per_pixel and row_bytes only while no transaction is in flight.
module png_row_unfilter
  import pru_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pru_in_if.sink                in_ch,
  pru_out_if.source             out_ch
);

  localparam int unsigned ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int unsigned COL_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned CMP_W  = (COL_W > ROW_BYTES_W) ? COL_W : ROW_BYTES_W;
  localparam int unsigned Q_W    = $bits(item_t) + ADDR_W;

  // configuration registers
  logic [BPP_W-1:0]       bpp_q;
  logic [ROW_BYTES_W-1:0] row_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BPP_W'(1);
      row_bytes_q <= ROW_BYTES_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BPP:       bpp_q       <= cfg_data_i[BPP_W-1:0];
        REG_ROW_BYTES: row_bytes_q <= cfg_data_i[ROW_BYTES_W-1:0];
        default:       ;
      endcase
    end
  end

  // out-of-range settings are clamped into the legal range
  logic [BPP_W-1:0] bpp_eff;
  logic [CMP_W-1:0] rb_wide;
  logic [CMP_W-1:0] rb_clamp;
  logic [COL_W-1:0] rb_eff;

  assign bpp_eff  = (bpp_q == '0) ? BPP_W'(1) :
                    (bpp_q > BPP_W'(MAX_BPP)) ? BPP_W'(MAX_BPP) : bpp_q;
  assign rb_wide  = CMP_W'(row_bytes_q);
  assign rb_clamp = (rb_wide == '0) ? CMP_W'(1) :
                    (rb_wide > CMP_W'(MAX_ROW_BYTES)) ? CMP_W'(MAX_ROW_BYTES) : rb_wide;
  assign rb_eff   = rb_clamp[COL_W-1:0];

  // front end to queue
  logic              q_push;
  item_t             f_item;
  logic [ADDR_W-1:0] f_col;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [Q_W-1:0]    q_rdata;
  item_t             b_item;
  logic [ADDR_W-1:0] b_col;

  pru_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .bpp_i       (bpp_eff),
    .row_bytes_i (rb_eff),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (f_item),
    .q_col_o     (f_col)
  );

  pru_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_col, f_item}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_item = item_t'(q_rdata[$bits(item_t)-1:0]);
  assign b_col  = q_rdata[Q_W-1:$bits(item_t)];

  // back end: line store, predictor, output register
  pru_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bpp_i     (bpp_eff),
    .q_empty_i (q_empty),
    .q_item_i  (b_item),
    .q_col_i   (b_col),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

  // queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue push while full");

  // queue never read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // an image start byte is always a filter type byte and yields no queue entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_ch.valid && in_ch.ready && in_ch.image_start) |-> !q_push)
    else $error("image start byte entered the queue");

  // a stalled result stays offered and unchanged until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_ch.valid && !out_ch.ready) |=>
                   (out_ch.valid && $stable(out_ch.pixel_byte) &&
                    $stable(out_ch.row_end) && $stable(out_ch.bad_filter)))
    else $error("stalled result changed");

endmodule

### bench/pru_pixel_check.sv
`timescale 1ns / 100ps

module pru_pixel_check
  import pru_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pru_in_if                     in_mon,
  pru_out_if                    out_mon,
  output int unsigned           err_cnt_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [RAW_W-1:0] pixel_byte;
    logic             row_end;
    logic             bad_filter;
  } pixel_t;

  pixel_t                 pixel_q[$];
  logic [RAW_W-1:0]       line_mem [MAX_ROW_BYTES_DEF];
  logic [ROW_BYTES_W-1:0] col;
  logic                   await_ft;
  logic                   top_row;
  logic                   err_flag;
  filter_e                kind;
  logic [31:0]            left_hist;
  logic [31:0]            up_hist;
  logic [BPP_W-1:0]       bpp_reg;
  logic [ROW_BYTES_W-1:0] rb_reg;
  int unsigned            mismatch_cnt;

  function automatic logic [RAW_W-1:0] paeth_pick(input logic [RAW_W-1:0] a,
                                                  input logic [RAW_W-1:0] b,
                                                  input logic [RAW_W-1:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // reconstruct one stream byte, queue the expected pixel for data bytes
  task automatic unfilter_byte(input logic [RAW_W-1:0] raw, input logic start);
    int unsigned      eb;
    int unsigned      erb;
    int unsigned      sh;
    logic [RAW_W-1:0] a;
    logic [RAW_W-1:0] b;
    logic [RAW_W-1:0] c;
    logic [RAW_W-1:0] pred;
    logic [RAW_W-1:0] val;
    pixel_t           px;
    eb  = (bpp_reg == 0) ? 1 : ((bpp_reg > MAX_BPP) ? MAX_BPP : bpp_reg);
    erb = (rb_reg == 0) ? 1 : ((rb_reg > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : rb_reg);
    sh  = 8 * (eb - 1);
    if (start) begin
      col      = '0;
      top_row  = 1'b1;
      err_flag = 1'b0;
      await_ft = 1'b1;
    end
    if (await_ft) begin
      if (raw > 8'd4) begin
        err_flag = 1'b1;
        kind     = FILT_BAD;
      end else begin
        kind = filter_e'(raw[2:0]);
      end
      col       = '0;
      left_hist = '0;
      up_hist   = '0;
      await_ft  = 1'b0;
    end else begin
      a = (col >= eb) ? left_hist[sh +: 8] : '0;
      b = (!top_row && col < MAX_ROW_BYTES_DEF) ? line_mem[col] : '0;
      c = (!top_row && col >= eb) ? up_hist[sh +: 8] : '0;
      case (kind)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = '0;
      endcase
      val = raw + pred;
      if (col < MAX_ROW_BYTES_DEF) line_mem[col] = val;
      left_hist = {left_hist[23:0], val};
      up_hist   = {up_hist[23:0], b};
      col       = col + 1'b1;
      px.row_end = (col >= erb);
      if (px.row_end) begin
        col      = '0;
        await_ft = 1'b1;
        top_row  = 1'b0;
      end
      px.pixel_byte = val;
      px.bad_filter = err_flag;
      pixel_q.push_back(px);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px;
    if (!rst_ni) begin
      pixel_q.delete();
      for (int i = 0; i < MAX_ROW_BYTES_DEF; i++) line_mem[i] = '0;
      col          = '0;
      await_ft     = 1'b1;
      top_row      = 1'b1;
      err_flag     = 1'b0;
      kind         = FILT_NONE;
      left_hist    = '0;
      up_hist      = '0;
      bpp_reg      = 3'd1;
      rb_reg       = 13'd1;
      mismatch_cnt = 0;
      err_cnt_o    <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BPP) bpp_reg = cfg_data_i[BPP_W-1:0];
        else if (cfg_idx_i == REG_ROW_BYTES) rb_reg = cfg_data_i[ROW_BYTES_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        unfilter_byte(in_mon.stream_byte, in_mon.image_start);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result: pixel_byte %0h row_end %0b bad_filter %0b",
                 out_mon.pixel_byte, out_mon.row_end, out_mon.bad_filter);
          mismatch_cnt++;
        end else begin
          px = pixel_q.pop_front();
          if (out_mon.pixel_byte !== px.pixel_byte) begin
            $error("pixel_byte: expected %0h, actual %0h", px.pixel_byte, out_mon.pixel_byte);
            mismatch_cnt++;
          end
          if (out_mon.row_end !== px.row_end) begin
            $error("row_end: expected %0b, actual %0b", px.row_end, out_mon.row_end);
            mismatch_cnt++;
          end
          if (out_mon.bad_filter !== px.bad_filter) begin
            $error("bad_filter: expected %0b, actual %0b", px.bad_filter, out_mon.bad_filter);
            mismatch_cnt++;
          end
        end
      end
      err_cnt_o <= mismatch_cnt;
      pending_o <= pixel_q.size();
    end
  end

endmodule

### bench/tb_png_row_unfilter.sv
`timescale 1ns / 100ps

module tb_png_row_unfilter;
  import pru_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned err_cnt;
  int unsigned pending;

  // idle percentages: sender side read only here, receiver side by its own process
  int unsigned src_idle;
  int unsigned snk_idle;
  // one long receiver hold-off, requested by the stimulus, counted by the receiver
  logic        hold_req;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  png_row_unfilter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  pru_pixel_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("png_row_unfilter test failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int unsigned hold_left;
    logic        held;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // idle modes: none, sender gaps, receiver stalls, both a little
  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin
        src_idle = 0;
        snk_idle <= 0;
      end
      1: begin
        src_idle = 46;
        snk_idle <= 0;
      end
      2: begin
        src_idle = 0;
        snk_idle <= 46;
      end
      default: begin
        src_idle = 10;
        snk_idle <= 10;
      end
    endcase
  endtask

  // offer one stream byte and wait for its transaction; valid stays high afterwards
  task automatic send_byte(input logic [RAW_W-1:0] raw, input logic start);
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= raw;
    in_ch.image_start <= start;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop offering, wait for every expected pixel, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // both registers, back to back, only while idle
  task automatic configure(input int unsigned bpp, input int unsigned rb);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BPP;
    cfg_data_i <= CFG_DATA_W'(bpp);
    @(posedge clk_i);
    cfg_idx_i  <= REG_ROW_BYTES;
    cfg_data_i <= CFG_DATA_W'(rb);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned phase;
    int unsigned bpp;
    int unsigned rb;
    int unsigned rb_eff;
    int unsigned n_img;
    int unsigned n_rows;
    int unsigned sel;
    logic [RAW_W-1:0] ft;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.stream_byte <= '0;
    in_ch.image_start <= 1'b0;
    hold_req          <= 1'b0;
    src_idle = 0;
    snk_idle <= 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: every filter type on two-byte rows, byte extremes, then a bad type
    configure(1, 2);
    send_byte(8'd0, 1'b1);   send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'd1, 1'b0);   send_byte(8'hFF, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'd2, 1'b0);   send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'd3, 1'b0);   send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'd4, 1'b0);   send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    // unknown type: bytes pass through, flag sticks for the image
    send_byte(8'hFF, 1'b0);  send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0);
    // new image clears the flag
    send_byte(8'd0, 1'b1);   send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
    settle();

    // row grows in the middle of a first row, widest pixel
    configure(4, 2);
    send_byte(8'd3, 1'b1);   send_byte(8'hC3, 1'b0);
    settle();
    configure(4, 4);
    send_byte(8'h11, 1'b0);  send_byte(8'h22, 1'b0); send_byte(8'h33, 1'b0);
    send_byte(8'd4, 1'b0);   send_byte(8'hF0, 1'b0); send_byte(8'h0F, 1'b0);
    send_byte(8'h80, 1'b0);  send_byte(8'h01, 1'b0);
    // row shrinks mid-row: next data byte already past the new length ends it
    send_byte(8'd2, 1'b0);   send_byte(8'h9A, 1'b0); send_byte(8'hBC, 1'b0);
    settle();
    configure(4, 1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'd1, 1'b0);   send_byte(8'h77, 1'b0);
    settle();

    // random: mostly well-formed images, some bad types and broken rows
    rand_items = 0;
    phase      = 0;
    while (rand_items < 1000) begin
      sel = $urandom_range(9);
      if (sel < 6) bpp = $urandom_range(1, 4);
      else if (sel == 6) bpp = 0;
      else if (sel == 7) bpp = $urandom_range(5, 7);
      else bpp = (sel == 8) ? 1 : 4;
      sel = $urandom_range(19);
      if (sel == 0) rb = 0;
      else if (sel == 1) rb = 1;
      else if (sel == 2) rb = $urandom_range(100, 300);
      else rb = $urandom_range(1, 24);
      rb_eff = (rb == 0) ? 1 : rb;
      configure(bpp, rb);
      set_idle(phase % 4);
      n_img = $urandom_range(1, 3);
      for (int img = 0; img < n_img; img++) begin
        n_rows = $urandom_range(1, 5);
        for (int row = 0; row < n_rows; row++) begin
          ft = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(4));
          send_byte(ft, (row == 0));
          rand_items++;
          for (int k = 0; k < rb_eff; k++) begin
            // now and then a new image cuts the row short
            if ($urandom_range(49) == 0) send_byte(8'($urandom_range(255)), 1'b1);
            else send_byte(8'($urandom_range(255)), 1'b0);
            rand_items++;
            // sender holds back until all pixels so far are out
            if (phase % 5 == 3 && img == 0 && row == 0 && k == 0) settle();
          end
        end
      end
      settle();
      phase++;
    end

    // two long rows, receiver holds off while the sender keeps offering
    configure(3, 256);
    set_idle(0);
    send_byte(8'd1, 1'b1);
    for (int k = 0; k < 256; k++) begin
      send_byte(8'($urandom_range(255)), 1'b0);
      if (k == 10) hold_req <= 1'b1;
    end
    send_byte(8'd4, 1'b0);
    for (int k = 0; k < 256; k++) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end
    settle();

    if (err_cnt == 0 && pending == 0) begin
      $display("png_row_unfilter test passed");
    end else begin
      $display("png_row_unfilter test failed");
    end
    $finish;
  end

endmodule
